@@ sv/hpe_pkg.sv @@
// Shared constants, types and helpers of the heatmap peak extractor
`default_nettype none

package hpe_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int KERNEL_SIZE = 5;
   localparam int RAD         = KERNEL_SIZE / 2;
   localparam int NCELL       = 2 * RAD + 1;
   localparam int NLANE       = RAD + 1;
   localparam int NROW        = 2 * RAD;
   localparam int NCAND       = NLANE * NLANE;
   localparam int CAND_W      = $clog2(NCAND);

   localparam int SAMPLE_W    = 16;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int DIM_W       = 9;
   localparam int COORD_W     = 8;
   localparam int RSP_W       = 2 * COORD_W + SAMPLE_W;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [COL_W-1:0]    col_type;
   typedef logic [ROW_W-1:0]    row_type;

   // element k holds row y-1-k of one column
   typedef sample_type [NROW-1:0]  line_type;
   typedef sample_type [NLANE-1:0] lane_vec_type;

   // one column of the window: per lane the vertical max and the centre sample
   typedef struct packed {
      logic         vld;
      lane_vec_type vmax;
      lane_vec_type ctr;
   } column_type;

   typedef struct packed {
      sample_type         value;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } peak_type;

   typedef peak_type [NCAND-1:0] peak_vec_type;
   typedef logic [NCAND-1:0]     cand_mask_type;

   function automatic sample_type max_of(input sample_type a, input sample_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

@@ sv/hpe_line_store.sv @@
// Line store: previous rows of each column packed in one word, with write forwarding
`default_nettype none

module hpe_line_store (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire hpe_pkg::col_type  wr_addr,
   input  wire hpe_pkg::line_type wr_data,
   input  wire hpe_pkg::col_type  rd_addr,
   output hpe_pkg::line_type      rd_data
);
   import hpe_pkg::*;

   line_type line_mem_ff [MAX_WIDTH];
   line_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   // write-first: a word written at the read address is seen at once
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

@@ sv/hpe_cell.sv @@
// Window cell: holds one column and extends the running horizontal max
`default_nettype none

module hpe_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift_en,
   input  wire hpe_pkg::column_type   col_in,
   input  wire hpe_pkg::lane_vec_type pmax_in,
   output hpe_pkg::column_type        col_out,
   output hpe_pkg::lane_vec_type      pmax_out,
   output hpe_pkg::lane_vec_type      ctr_out
);
   import hpe_pkg::*;

   logic         vld_ff;
   lane_vec_type vmax_ff;
   lane_vec_type ctr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (shift_en) begin
         vld_ff <= col_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         vmax_ff <= col_in.vmax;
         ctr_ff  <= col_in.ctr;
      end
   end

   // columns left of the frame read as zero
   always_comb begin
      col_out = '{vld: vld_ff, vmax: vmax_ff, ctr: ctr_ff};
      for (int l = 0; l < NLANE; l++) begin
         pmax_out[l] = max_of(pmax_in[l], vld_ff ? vmax_ff[l] : sample_type'(0));
         ctr_out[l]  = vld_ff ? ctr_ff[l] : sample_type'(0);
      end
   end

endmodule

`default_nettype wire

@@ sv/hpe_emit.sv @@
// Peak buffer: holds the peaks of one step and hands them out one word at a time
`default_nettype none

module hpe_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load_req,
   input  wire hpe_pkg::cand_mask_type load_mask,
   input  wire hpe_pkg::peak_vec_type  load_peaks,
   output logic                        load_ok,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output hpe_pkg::peak_type           out_peak,
   output logic                        out_last
);
   import hpe_pkg::*;

   cand_mask_type     mask_ff;
   cand_mask_type     mask_in;
   cand_mask_type     mask_left;
   peak_vec_type      peaks_ff;
   logic              out_valid_ff;
   peak_type          out_peak_ff;
   logic              out_last_ff;
   logic              out_free;
   logic              pop;
   logic [CAND_W-1:0] sel;

   always_comb begin
      out_free = !out_valid_ff || out_ready;
      pop      = out_free && (mask_ff != '0);
      sel      = '0;
      for (int i = NCAND - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = CAND_W'(i);
         end
      end
      mask_left = mask_ff;
      if (pop) begin
         mask_left[sel] = 1'b0;
      end
      load_ok = (mask_left == '0);
      mask_in = (load_req && load_ok) ? load_mask : mask_left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (out_free) begin
            out_valid_ff <= pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_req && load_ok) begin
         peaks_ff <= load_peaks;
      end
      if (pop) begin
         out_peak_ff <= peaks_ff[sel];
         out_last_ff <= (mask_left == '0);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_peak  = out_peak_ff;
   assign out_last  = out_last_ff;

endmodule

`default_nettype wire

@@ sv/heatmap_peak_extract.sv @@
// Heatmap peak extractor: 5x5 clipped-window non-maximum suppression on a raster stream
//
//   port group | direction | word
//   req_       | in        | tdata[15:0] belief
//   rsp_       | out       | tdata[7:0] peak_x, [15:8] peak_y, [31:16] peak_value; tlast
//   csr_       | in        | index 0 frame_width, 1 frame_height, 2 peak_threshold
//
// One sample per cycle while req_tready is high; peaks pass the window stage, peak buffer and
// output register. A sample closing several windows with peaks holds req_tready low while the
// buffer drains (longest on a frame's last sample), set by the single-word output register.
// Reset is synchronous; no clearing pass: line store rows above row 0 are masked by row count.
// Back-pressure on rsp_ fills the peak buffer, then the window stage, then drops req_tready.
// A register write restarts the frame at (0,0).
`default_nettype none

module heatmap_peak_extract (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [hpe_pkg::SAMPLE_W-1:0]     req_tdata,   // [15:0] belief
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [hpe_pkg::RSP_W-1:0]             rsp_tdata,   // [7:0] peak_x, [15:8] peak_y,
                                                              // [31:16] peak_value
   output logic                                  rsp_tlast,
   input  wire logic                             csr_wen,
   input  wire logic [hpe_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [hpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hpe_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK_THRESHOLD = 2'd2;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET    = 9'd40;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET   = 9'd30;
   localparam sample_type       PEAK_THRESHOLD_RESET = 16'd39322;

   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;
   sample_type       peak_threshold_ff;

   col_type col_ff, col_in, w_last;
   row_type row_ff, row_in, h_last;
   logic    accept, csr_hit, at_col_end, at_row_end;

   line_type              rd_line, wr_line;
   sample_type [NROW:0]   vrow;
   sample_type [NROW:0]   vpre;
   column_type            head;

   column_type   link  [NCELL];
   column_type   chain [NCELL];
   lane_vec_type pm    [NCELL+1];
   lane_vec_type ctr   [NCELL];

   logic    s1_vld_ff;
   col_type s1_col_ff;
   row_type s1_row_ff;
   logic    s1_col_end_ff, s1_row_end_ff;

   cand_mask_type cand_mask;
   peak_vec_type  cand_peaks;
   logic          load_ok;
   peak_type      out_peak;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RESET;
         frame_height_ff   <= FRAME_HEIGHT_RESET;
         peak_threshold_ff <= PEAK_THRESHOLD_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata[DIM_W-1:0];
            CSR_PEAK_THRESHOLD: peak_threshold_ff <= csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_hit = csr_wen && (csr_addr == CSR_FRAME_WIDTH || csr_addr == CSR_FRAME_HEIGHT
                                || csr_addr == CSR_PEAK_THRESHOLD);

   // last column and row, zero acting as one and large values clamped
   always_comb begin
      if (frame_width_ff == '0) begin
         w_last = '0;
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         w_last = col_type'(MAX_WIDTH - 1);
      end else begin
         w_last = col_type'(frame_width_ff - 1'b1);
      end
      if (frame_height_ff == '0) begin
         h_last = '0;
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         h_last = row_type'(MAX_HEIGHT - 1);
      end else begin
         h_last = row_type'(frame_height_ff - 1'b1);
      end
   end

   // ---- raster position ----
   assign accept     = req_tvalid && req_tready;
   assign at_col_end = (col_ff == w_last);
   assign at_row_end = (row_ff == h_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (at_col_end) begin
            col_in = '0;
            row_in = at_row_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---- line store, read one word ahead at the next column ----
   hpe_line_store u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (wr_line),
      .rd_addr (col_in),
      .rd_data (rd_line)
   );

   // vertical maxima; lane d is centred on row y-RAD+d, rows above the frame read as zero
   always_comb begin
      vrow[0] = req_tdata;
      for (int k = 1; k <= NROW; k++) begin
         vrow[k] = (int'(row_ff) >= k) ? rd_line[k-1] : sample_type'(0);
      end
      vpre[0] = vrow[0];
      for (int k = 1; k <= NROW; k++) begin
         vpre[k] = max_of(vpre[k-1], vrow[k]);
      end
      head.vld = 1'b1;
      for (int d = 0; d < NLANE; d++) begin
         head.vmax[d] = vpre[NROW-d];
         head.ctr[d]  = vrow[RAD-d];
      end
      for (int k = 0; k < NROW; k++) begin
         wr_line[k] = vrow[k];
      end
   end

   // ---- cell chain, newest column in cell 0 ----
   always_comb begin
      link[0] = head;
      for (int k = 1; k < NCELL; k++) begin
         link[k]     = chain[k-1];
         link[k].vld = chain[k-1].vld && (col_ff != '0);
      end
   end

   assign pm[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      hpe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .col_in   (link[k]),
         .pmax_in  (pm[k]),
         .col_out  (chain[k]),
         .pmax_out (pm[k+1]),
         .ctr_out  (ctr[k])
      );
   end

   // ---- window stage ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (load_ok) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_col_end_ff <= at_col_end;
         s1_row_end_ff <= at_row_end;
      end
   end

   assign req_tready = !s1_vld_ff || load_ok;

   // candidates in raster order: lane (row) major, then column offset
   always_comb begin : cand_build
      int         i;
      int         c;
      logic       lane_ok;
      logic       pos_ok;
      sample_type v;
      sample_type wmax;
      cand_mask  = '0;
      cand_peaks = '0;
      for (int d = 0; d < NLANE; d++) begin
         for (int e = 0; e < NLANE; e++) begin
            i       = d * NLANE + e;
            c       = RAD - e;
            lane_ok = (int'(s1_row_ff) >= RAD - d) && (d == 0 || s1_row_end_ff);
            pos_ok  = (int'(s1_col_ff) >= RAD - e) && (e == 0 || s1_col_end_ff);
            v       = ctr[c][d];
            wmax    = pm[c+RAD+1][d];
            cand_mask[i]        = lane_ok && pos_ok && (v >= peak_threshold_ff) && (v >= wmax);
            cand_peaks[i].x     = COORD_W'(int'(s1_col_ff) + e - RAD);
            cand_peaks[i].y     = COORD_W'(int'(s1_row_ff) + d - RAD);
            cand_peaks[i].value = v;
         end
      end
   end

   // ---- peak buffer and output register ----
   hpe_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_req   (s1_vld_ff),
      .load_mask  (cand_mask),
      .load_peaks (cand_peaks),
      .load_ok    (load_ok),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_peak   (out_peak),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = out_peak;

endmodule

`default_nettype wire

@@ sv/hpe_checker.sv @@
// Port-level checks of the heatmap peak extractor, bound to the top level
`default_nettype none

module hpe_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [hpe_pkg::SAMPLE_W-1:0]     req_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [hpe_pkg::RSP_W-1:0]        rsp_tdata,
   input wire logic                             rsp_tlast,
   input wire logic                             csr_wen,
   input wire logic [hpe_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input wire logic [hpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   logic seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         seen_ff <= 1'b1;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled peak word changed");

   a_peak_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> seen_ff)
      else $error("peak word without any sample taken");

   a_run_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a run of peaks");

   // keep unused port bits visibly consumed
   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_wen, csr_addr, csr_wdata};

endmodule

bind heatmap_peak_extract hpe_checker u_hpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_wen    (csr_wen),
   .csr_addr   (csr_addr),
   .csr_wdata  (csr_wdata)
);

`default_nettype wire

@@ tb/heatmap_peak_extract_tb.sv @@
// Self-checking testbench: raster heatmap streams against a window peak predictor
module heatmap_peak_extract_tb;
   import hpe_pkg::*;

   localparam int ROWS_KEPT      = NCELL;
   localparam int IDLE_SETTLE    = 10;
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TX_SIDE        = 0;
   localparam int RX_SIDE        = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_THRESH = 2'd2,
      REG_SPARE  = 2'd3
   } reg_idx_t;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      sample_type         value;
      logic               is_last;
   } peak_rec_t;

   typedef struct packed {
      row_kind_t  kind;
      reg_idx_t   idx;
      sample_type data;
      logic       typed;
      peak_rec_t  want;
   } stim_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   heatmap_peak_extract u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   sample_type       belief_rows [ROWS_KEPT][MAX_WIDTH];
   logic [DIM_W-1:0] cfg_width  = 9'd40;
   logic [DIM_W-1:0] cfg_height = 9'd30;
   sample_type       cfg_thresh = 16'd39322;
   int unsigned      next_col = 0;
   int unsigned      next_row = 0;
   peak_rec_t        pending_peaks[$];

   int          fail_count = 0;
   int          samples_sent = 0;
   int          peaks_seen = 0;
   int          writes_done = 0;
   bit          calm_side[2];
   int unsigned words_side[2];
   int unsigned quiet_cycles = 0;
   logic        long_stall_req = 1'b0;
   logic        long_stall_taken = 1'b0;
   int unsigned long_left = 0;
   int unsigned gap_left = 0;
   int unsigned rx_draw;

   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // centres along one axis whose window closes at position p
   function automatic bit axis_closes(input int unsigned p, input int unsigned n,
                                      output int unsigned lo, output int unsigned hi);
      if (p == n - 1) begin
         lo = (p >= RAD) ? p - RAD : 0;
         hi = p;
         return 1'b1;
      end
      if (p >= RAD) begin
         lo = p - RAD;
         hi = lo;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit centre_wins(input int unsigned cx, input int unsigned cy,
                                      input int unsigned w, input int unsigned h);
      sample_type  v;
      sample_type  m;
      int unsigned x0, y0, x1, y1;
      v  = belief_rows[cy % ROWS_KEPT][cx];
      m  = '0;
      x0 = (cx >= RAD) ? cx - RAD : 0;
      y0 = (cy >= RAD) ? cy - RAD : 0;
      x1 = (cx + RAD > w - 1) ? w - 1 : cx + RAD;
      y1 = (cy + RAD > h - 1) ? h - 1 : cy + RAD;
      if (v < cfg_thresh) return 1'b0;
      for (int unsigned yy = y0; yy <= y1; yy++)
         for (int unsigned xx = x0; xx <= x1; xx++)
            if (belief_rows[yy % ROWS_KEPT][xx] > m) m = belief_rows[yy % ROWS_KEPT][xx];
      return v >= m;
   endfunction

   // takes one sample, queues the peaks it releases, returns how many
   function automatic int find_peaks(input sample_type b);
      int unsigned w, h, x, y, xlo, xhi, ylo, yhi;
      int          n;
      peak_rec_t   found[NCAND];
      w = eff_dim(cfg_width, MAX_WIDTH);
      h = eff_dim(cfg_height, MAX_HEIGHT);
      x = next_col;
      y = next_row;
      n = 0;
      if (x >= w) x = 0;
      if (y >= h) y = 0;
      belief_rows[y % ROWS_KEPT][x] = b;
      if (axis_closes(x, w, xlo, xhi) && axis_closes(y, h, ylo, yhi))
         for (int unsigned cy = ylo; cy <= yhi; cy++)
            for (int unsigned cx = xlo; cx <= xhi; cx++)
               if (centre_wins(cx, cy, w, h)) begin
                  found[n] = '{x: cx[COORD_W-1:0], y: cy[COORD_W-1:0],
                               value: belief_rows[cy % ROWS_KEPT][cx], is_last: 1'b0};
                  n++;
               end
      for (int i = 0; i < n; i++) begin
         found[i].is_last = (i == n - 1);
         pending_peaks.push_back(found[i]);
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      next_col = x;
      next_row = y;
      return n;
   endfunction

   function automatic void apply_write(input reg_idx_t idx, input logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_WIDTH:  cfg_width  = d[DIM_W-1:0];
         REG_HEIGHT: cfg_height = d[DIM_W-1:0];
         REG_THRESH: cfg_thresh = d;
         default:    ;
      endcase
      if (idx != REG_SPARE) begin
         next_col = 0;
         next_row = 0;
      end
   endfunction

   // random idle gap before each word, with calm stretches of no idling
   function automatic int unsigned draw_gap(input int side);
      words_side[side]++;
      if (words_side[side] % 24 == 0) calm_side[side] = ($urandom_range(0, 2) == 0);
      return calm_side[side] ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic sample_type draw_belief();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sample_type'($urandom);
         4, 5: begin
            case ($urandom_range(0, 3))
               0:       return 16'h0000;
               1:       return 16'h8000;
               2:       return 16'h9999;
               default: return 16'hFFFF;
            endcase
         end
         default: return sample_type'($urandom_range(0, 16'h3FFF));
      endcase
   endfunction

   function automatic sample_type draw_thresh();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'd39322;
         3:       return sample_type'($urandom);
         default: return sample_type'($urandom_range(16'h2000, 16'h8000));
      endcase
   endfunction

   function automatic stim_row_t wr_row(input reg_idx_t idx, input sample_type d);
      return '{kind: ROW_WRITE, idx: idx, data: d, typed: 1'b0, want: '0};
   endfunction

   function automatic stim_row_t belief_row(input sample_type b);
      return '{kind: ROW_SAMPLE, idx: REG_SPARE, data: b, typed: 1'b0, want: '0};
   endfunction

   function automatic stim_row_t peak_row(input sample_type b, input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y, input sample_type v);
      return '{kind: ROW_SAMPLE, idx: REG_SPARE, data: b, typed: 1'b1,
               want: '{x: x, y: y, value: v, is_last: 1'b1}};
   endfunction

   function automatic void check_peak(input logic [RSP_W-1:0] d, input logic l);
      peak_rec_t e;
      peaks_seen++;
      if (pending_peaks.size() == 0) begin
         $error("peak word with none expected: x=%0d y=%0d value=%0h",
                d[COORD_W-1:0], d[2*COORD_W-1:COORD_W], d[RSP_W-1:2*COORD_W]);
         fail_count++;
         return;
      end
      e = pending_peaks.pop_front();
      if (d[COORD_W-1:0] !== e.x) begin
         $error("peak_x expected %0d got %0d", e.x, d[COORD_W-1:0]);
         fail_count++;
      end
      if (d[2*COORD_W-1:COORD_W] !== e.y) begin
         $error("peak_y expected %0d got %0d", e.y, d[2*COORD_W-1:COORD_W]);
         fail_count++;
      end
      if (d[RSP_W-1:2*COORD_W] !== e.value) begin
         $error("peak_value expected %0h got %0h", e.value, d[RSP_W-1:2*COORD_W]);
         fail_count++;
      end
      if (l !== e.is_last) begin
         $error("last expected %0b got %0b", e.is_last, l);
         fail_count++;
      end
   endfunction

   // receiver: random gaps plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         gap_left   <= 0;
         long_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_peak(rsp_tdata, rsp_tlast);
         if (long_stall_req && !long_stall_taken) begin
            long_stall_taken <= 1'b1;
            long_left        <= LONG_STALL;
            rsp_tready       <= 1'b0;
         end else if (long_left > 1) begin
            long_left <= long_left - 1;
         end else if (long_left == 1) begin
            long_left  <= 0;
            rsp_tready <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            rx_draw = draw_gap(RX_SIDE);
            gap_left   <= rx_draw;
            rsp_tready <= (rx_draw == 0);
         end else if (!rsp_tready) begin
            if (gap_left > 1) begin
               gap_left <= gap_left - 1;
            end else begin
               gap_left   <= 0;
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("no traffic for %0d cycles, %0d peak words outstanding",
                  WATCHDOG_LIMIT, pending_peaks.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic idle_wait();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_peaks.size() != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic cfg_write(input reg_idx_t idx, input logic [CSR_DATA_W-1:0] d);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_wen <= 1'b0;
      apply_write(idx, d);
      writes_done++;
   endtask

   task automatic send_word(input sample_type b, output int n);
      int unsigned g;
      g = draw_gap(TX_SIDE);
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      n = find_peaks(b);
      samples_sent++;
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] w_word, input logic [CSR_DATA_W-1:0] h_word,
                            input sample_type thr, input int count, input bit pause_midway);
      int n;
      if ($urandom_range(0, 3) == 0) begin
         idle_wait();
         cfg_write(REG_SPARE, CSR_DATA_W'($urandom));
      end
      idle_wait();
      cfg_write(REG_WIDTH, w_word);
      idle_wait();
      cfg_write(REG_HEIGHT, h_word);
      idle_wait();
      cfg_write(REG_THRESH, thr);
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_peaks.size() != 0);
         end
         send_word(draw_belief(), n);
      end
   endtask

   initial begin
      stim_row_t              directed_rows[$];
      logic [CSR_DATA_W-1:0]  w, h;
      int                     n;

      foreach (belief_rows[r, c]) belief_rows[r][c] = '0;

      // 1x1 frames: every sample at or above threshold is its own peak
      directed_rows.push_back(wr_row(REG_THRESH, 16'h0000));
      directed_rows.push_back(wr_row(REG_WIDTH, 16'h0000));
      directed_rows.push_back(wr_row(REG_HEIGHT, 16'h0000));
      directed_rows.push_back(peak_row(16'h0000, 8'd0, 8'd0, 16'h0000));
      directed_rows.push_back(peak_row(16'hFFFF, 8'd0, 8'd0, 16'hFFFF));
      directed_rows.push_back(wr_row(REG_THRESH, 16'hFFFF));
      directed_rows.push_back(belief_row(16'hFFFE));
      directed_rows.push_back(peak_row(16'hFFFF, 8'd0, 8'd0, 16'hFFFF));
      // write past the last register must leave the threshold alone
      directed_rows.push_back(wr_row(REG_SPARE, 16'h0000));
      directed_rows.push_back(belief_row(16'h1234));
      directed_rows.push_back(wr_row(REG_THRESH, 16'h8000));
      directed_rows.push_back(peak_row(16'h8000, 8'd0, 8'd0, 16'h8000));
      // 3x3 plateau: all nine centres close on the last sample
      directed_rows.push_back(wr_row(REG_THRESH, 16'h0000));
      directed_rows.push_back(wr_row(REG_WIDTH, 16'd3));
      directed_rows.push_back(wr_row(REG_HEIGHT, 16'd3));
      repeat (9) directed_rows.push_back(belief_row(16'h8000));
      // second frame: lone maximum in the middle suppresses everything else
      repeat (4) directed_rows.push_back(belief_row(16'h0001));
      directed_rows.push_back(belief_row(16'hFFFF));
      repeat (3) directed_rows.push_back(belief_row(16'h0001));
      directed_rows.push_back(peak_row(16'h0001, 8'd1, 8'd1, 16'hFFFF));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            idle_wait();
            cfg_write(directed_rows[r].idx, directed_rows[r].data);
         end else begin
            send_word(directed_rows[r].data, n);
            if (directed_rows[r].typed) begin
               repeat (n) void'(pending_peaks.pop_back());
               pending_peaks.push_back(directed_rows[r].want);
            end
         end
      end

      // output held off long enough to back up into the input
      run_phase(16'd2, 16'd2, 16'h0000, 0, 1'b0);
      long_stall_req <= 1'b1;
      for (int i = 0; i < 48; i++) send_word(draw_belief(), n);

      // widest and tallest frames, oversized values clamp to the maximum
      run_phase(16'hFFFF, 16'd1, 16'h9999, 260, 1'b0);
      run_phase(16'd1, 16'd300, 16'h9999, 256, 1'b0);
      run_phase(16'd256, 16'd256, draw_thresh(), 20, 1'b0);

      for (int p = 0; p < 9; p++) begin
         w = $urandom_range(0, 10);
         h = $urandom_range(0, 10);
         if ((p % 2) == 1) begin
            w[CSR_DATA_W-1:DIM_W] = $urandom;
            h[CSR_DATA_W-1:DIM_W] = $urandom;
         end
         run_phase(w, h, draw_thresh(), $urandom_range(12, 40), p == 0);
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_peaks.size() != 0);
      repeat (4 * IDLE_SETTLE) @(posedge clock);
      if (pending_peaks.size() != 0) begin
         $error("%0d expected peak words never arrived", pending_peaks.size());
         fail_count += pending_peaks.size();
      end

      $display("%0d samples sent, %0d peak words checked, %0d register writes",
               samples_sent, peaks_seen, writes_done);
      $display("frames from 1x1 up to 256 wide and 256 tall, thresholds 0 to ffff, long output stall");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/hpe_pkg.sv
sv/hpe_line_store.sv
sv/hpe_cell.sv
sv/hpe_emit.sv
sv/heatmap_peak_extract.sv
sv/hpe_checker.sv
tb/heatmap_peak_extract_tb.sv
